// File: rtl/core/snu_pkg.sv
// Shared types, constants and helpers for the spiking neuron update block.
package snu_pkg;

	localparam int SYNAPSES_DEF = 64;
	localparam int IDX_W        = 6;
	localparam int VAL_W        = 16;
	localparam int DECAY_W      = 16;
	localparam int TRACE_W      = 48;
	localparam int DRIVE_W      = 40;
	localparam int PEN_W        = 33;
	localparam int THR_W        = 26;
	localparam int LEAK_W       = 17;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 33;
	// must be a power of two, pointers wrap naturally
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [LEAK_W-1:0] LEAK_ONE = 17'h10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPIKE_PENALTY  = 2'd0,
		CFG_FIRE_THRESHOLD = 2'd1,
		CFG_LEAK_COEFF     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0]         synapse_index;
		logic signed [VAL_W-1:0]  input_value;
		logic signed [VAL_W-1:0]  weight;
		logic [DECAY_W-1:0]       decay_factor;
		logic                     last_in_step;
	} item_t;

	typedef struct packed {
		logic                      fired;
		logic signed [TRACE_W-1:0] membrane_potential;
	} result_t;

	typedef struct packed {
		logic [PEN_W-1:0]  penalty;
		logic [THR_W-1:0]  threshold;
		logic [LEAK_W-1:0] leak;
	} cfg_regs_t;

	// classified synapse word as it travels from front to back
	typedef struct packed {
		logic                      hit;
		logic                      last;
		logic [IDX_W-1:0]          idx;
		logic [DECAY_W-1:0]        decay;
		logic signed [DRIVE_W-1:0] drive;
	} syn_op_t;

	typedef enum logic [1:0] {
		FIRE_IDLE,
		FIRE_MUL,
		FIRE_ADD,
		FIRE_OUT
	} fire_state_t;

	function automatic logic signed [TRACE_W-1:0] sat48(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_7FFF_FFFF_FFFF;
		lo = -hi - 64'sd1;
		if (v > hi) begin
			return hi[TRACE_W-1:0];
		end else if (v < lo) begin
			return lo[TRACE_W-1:0];
		end else begin
			return v[TRACE_W-1:0];
		end
	endfunction

endpackage

// File: rtl/core/snu_front.sv
// Front end: accept input words, compute the synaptic drive and classify the index.
module snu_front import snu_pkg::*; #(
	parameter int SYNAPSES = SYNAPSES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	input  logic    clearing,
	output logic    op_valid,
	input  logic    op_ready,
	output syn_op_t op
);

	localparam int SYN_BITS = $clog2(SYNAPSES + 1);
	localparam int CMP_W    = (SYN_BITS > IDX_W) ? SYN_BITS : IDX_W;

	logic                 op_valid_q;
	syn_op_t              op_q;
	logic signed [31:0]   wx;
	logic                 accept;
	logic                 hit;

	assign wx         = item.weight * item.input_value;
	assign hit        = CMP_W'(item.synapse_index) < CMP_W'(SYNAPSES);
	assign item_ready = !clearing && (!op_valid_q || op_ready);
	assign accept     = item_valid && item_ready;
	assign op_valid   = op_valid_q;
	assign op         = op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_q <= 1'b0;
		end else if (accept) begin
			op_valid_q <= 1'b1;
		end else if (op_ready) begin
			op_valid_q <= 1'b0;
		end
	end

	// Q24.8 product moved up to Q24.16
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q.hit   <= hit;
			op_q.last  <= item.last_in_step;
			op_q.idx   <= item.synapse_index;
			op_q.decay <= item.decay_factor;
			op_q.drive <= $signed({wx, 8'h00});
		end
	end

endmodule

// File: rtl/core/snu_fifo.sv
// Short queue of classified synapse words between front and back end.
module snu_fifo import snu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  syn_op_t push_op,
	output logic    pop_valid,
	input  logic    pop,
	output syn_op_t pop_op
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	syn_op_t          slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != (PTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_op     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// File: rtl/core/snu_back.sv
// Back end: trace memory read-modify-write pipeline and running sum.
module snu_back import snu_pkg::*; #(
	parameter int SYNAPSES = SYNAPSES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	input  syn_op_t                   head,
	output logic                      head_pop,
	output logic                      clearing,
	output logic                      hand_valid,
	output logic signed [TRACE_W-1:0] hand_sum,
	input  logic                      hand_ready
);

	localparam int ADDR_W = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;

	logic signed [TRACE_W-1:0] mem_q [SYNAPSES];

	logic                      clr_q;
	logic [ADDR_W-1:0]         clr_addr_q;
	logic signed [TRACE_W-1:0] sum_q;

	logic                      v_s1;
	syn_op_t                   op_s1;
	logic signed [TRACE_W-1:0] trace_s1;
	logic                      v_s2;
	syn_op_t                   op_s2;
	logic signed [64:0]        prod_s2;
	logic                      v_s3;
	logic                      hit_s3;
	logic                      last_s3;
	logic signed [TRACE_W-1:0] t_s3;

	logic                      adv;
	logic                      hazard;
	logic                      fwd;
	logic [ADDR_W+IDX_W-1:0]   head_ext;
	logic [ADDR_W+IDX_W-1:0]   s2_ext;
	logic [ADDR_W-1:0]         head_addr;
	logic [ADDR_W-1:0]         s2_addr;
	logic signed [64:0]        prod;
	logic signed [48:0]        kept_s2;
	logic signed [TRACE_W-1:0] t_s2;
	logic                      wr_en;
	logic [ADDR_W-1:0]         wr_addr;
	logic signed [TRACE_W-1:0] wr_data;
	logic signed [TRACE_W-1:0] sum_new;

	assign head_ext  = {{ADDR_W{1'b0}}, head.idx};
	assign s2_ext    = {{ADDR_W{1'b0}}, op_s2.idx};
	assign head_addr = head_ext[ADDR_W-1:0];
	assign s2_addr   = s2_ext[ADDR_W-1:0];

	// hold the whole pipe while a last word waits for the fire unit
	assign adv      = !(v_s3 && last_s3 && !hand_ready);
	// the trace of the word just ahead is not written yet: insert a bubble
	assign hazard   = head.hit && v_s1 && op_s1.hit && (op_s1.idx == head.idx);
	assign head_pop = adv && head_valid && !clr_q && !hazard;
	// the word two ahead writes on the same edge as this read: bypass
	assign fwd      = v_s2 && op_s2.hit && (op_s2.idx == head.idx);
	assign clearing = clr_q;

	assign prod    = trace_s1 * $signed({1'b0, op_s1.decay});
	assign kept_s2 = $signed(prod_s2[64:16]);
	assign t_s2    = sat48(64'(op_s2.drive) + 64'(kept_s2));

	assign wr_en   = clr_q || (adv && v_s2 && op_s2.hit);
	assign wr_addr = clr_q ? clr_addr_q : s2_addr;
	assign wr_data = clr_q ? '0 : t_s2;

	assign sum_new    = sat48(64'(sum_q) + (hit_s3 ? 64'(t_s3) : 64'sd0));
	assign hand_valid = v_s3 && last_s3;
	assign hand_sum   = sum_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == ADDR_W'(SYNAPSES - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			sum_q <= '0;
		end else if (adv) begin
			v_s1 <= head_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				sum_q <= last_s3 ? '0 : sum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= head;
			trace_s1 <= fwd ? t_s2 : mem_q[head_addr];
			op_s2    <= op_s1;
			prod_s2  <= prod;
			hit_s3   <= op_s2.hit;
			last_s3  <= op_s2.last;
			t_s3     <= t_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

endmodule

// File: rtl/core/snu_fire.sv
// Fire unit: refractory update, threshold decision and result register.
module snu_fire import snu_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      hand_valid,
	input  logic signed [TRACE_W-1:0] hand_sum,
	output logic                      hand_ready,
	input  cfg_regs_t                 cfg,
	output logic                      result_valid,
	input  logic                      result_ready,
	output result_t                   result
);

	fire_state_t               state_q;
	fire_state_t               state_d;
	logic                      load_sum;
	logic                      load_out;

	logic signed [TRACE_W-1:0] sum_q;
	logic signed [TRACE_W-1:0] ref_q;
	logic                      spike_q;
	logic signed [65:0]        prod_q;
	logic                      out_valid_q;
	result_t                   out_q;

	logic [PEN_W-1:0]          pen_sel;
	logic signed [49:0]        kept;
	logic signed [63:0]        acc;
	logic signed [TRACE_W-1:0] ref_next;
	logic signed [TRACE_W-1:0] u;

	assign pen_sel  = spike_q ? cfg.penalty : '0;
	assign kept     = $signed(prod_q[65:16]);
	assign acc      = 64'(pen_sel) + 64'(kept) + 64'(cfg.threshold);
	assign ref_next = sat48(-acc);
	assign u        = sat48(64'(sum_q) + 64'(ref_q));

	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FIRE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		hand_ready = 1'b0;
		load_sum   = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			FIRE_IDLE: begin
				hand_ready = 1'b1;
				if (hand_valid) begin
					load_sum = 1'b1;
					state_d  = FIRE_MUL;
				end
			end
			FIRE_MUL: begin
				state_d = FIRE_ADD;
			end
			FIRE_ADD: begin
				state_d = FIRE_OUT;
			end
			FIRE_OUT: begin
				if (!out_valid_q || result_ready) begin
					load_out = 1'b1;
					state_d  = FIRE_IDLE;
				end
			end
			default: begin
				state_d = FIRE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q       <= '0;
			spike_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == FIRE_ADD) begin
				ref_q <= ref_next;
			end
			if (load_out) begin
				spike_q     <= !u[TRACE_W-1];
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_sum) begin
			sum_q <= hand_sum;
		end
		if (state_q == FIRE_MUL) begin
			prod_q <= ref_q * $signed({1'b0, cfg.leak});
		end
		if (load_out) begin
			out_q.fired              <= !u[TRACE_W-1];
			out_q.membrane_potential <= u;
		end
	end

endmodule

// File: rtl/core/spiking_neuron_update.sv
// Top level of the spiking neuron update block.
//
// Usage:
// - item channel (item_valid/item_ready/item): one word per synapse of a time
//   step; the word with last_in_step set closes the step.
// - result channel (result_valid/result_ready/result): one word per closed
//   step, carrying the fired flag and the membrane potential (Q32.16).
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; write only while no word is in flight.
// Throughput: one synapse word per cycle outside the reset sweep while the back
// end does not stall. Two words on the same synapse back to back insert a
// bubble in the trace read-modify-write loop. A closing word holds the fire
// unit through its MUL, ADD and OUT states, and the next closing word waits
// until the fire unit is idle again.
// Reset: the control registers clear, then a sweep zeroes the trace memory,
// one entry per cycle; item_ready stays low during the sweep.
// Stall: a held result blocks the fire unit, the back end then halts on the
// next closing word, and the queue and front fill before item_ready drops.
module spiking_neuron_update import snu_pkg::*; #(
	parameter int SYNAPSES = SYNAPSES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_regs_t                 cfg_q;
	logic                      clearing;
	logic                      op_valid;
	logic                      op_ready;
	syn_op_t                   op;
	logic                      head_valid;
	logic                      head_pop;
	syn_op_t                   head;
	logic                      hand_valid;
	logic                      hand_ready;
	logic signed [TRACE_W-1:0] hand_sum;
	logic [LEAK_W-1:0]         leak_wr;

	assign cfg_ready = 1'b1;
	assign leak_wr   = cfg_data[LEAK_W-1:0];

	// Configuration registers; clamp the leak at one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SPIKE_PENALTY: begin
					cfg_q.penalty <= cfg_data[PEN_W-1:0];
				end
				CFG_FIRE_THRESHOLD: begin
					cfg_q.threshold <= cfg_data[THR_W-1:0];
				end
				CFG_LEAK_COEFF: begin
					cfg_q.leak <= (leak_wr > LEAK_ONE) ? LEAK_ONE : leak_wr;
				end
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

	// Classify words and form the drive.
	snu_front #(
		.SYNAPSES(SYNAPSES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.clearing  (clearing),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op)
	);

	// Decouple front and back.
	snu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(op_valid),
		.push_ready(op_ready),
		.push_op   (op),
		.pop_valid (head_valid),
		.pop       (head_pop),
		.pop_op    (head)
	);

	// Update traces and accumulate the step sum.
	snu_back #(
		.SYNAPSES(SYNAPSES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.head_pop  (head_pop),
		.clearing  (clearing),
		.hand_valid(hand_valid),
		.hand_sum  (hand_sum),
		.hand_ready(hand_ready)
	);

	// Close the step: refractory term, fire decision, result word.
	snu_fire u_fire (
		.clk         (clk),
		.arst_n      (arst_n),
		.hand_valid  (hand_valid),
		.hand_sum    (hand_sum),
		.hand_ready  (hand_ready),
		.cfg         (cfg_q),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

// File: rtl/core/snu_checks.sv
// Port-level checks for the spiking neuron update block, bound to the top level.
module snu_checks import snu_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input item_t   item,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	logic [4:0] pending_q;
	logic       last_in;
	logic       res_out;

	assign last_in = item_valid && item_ready && item.last_in_step;
	assign res_out = result_valid && result_ready;

	// count closing words not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_in && !res_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (res_out && !last_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed or dropped while stalled");

	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != '0)
		else $error("result word without a closing input word");

	a_fire_sign: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.fired == !result.membrane_potential[TRACE_W-1])
		else $error("fired flag disagrees with potential sign");

	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !item_ready)
		else $error("input taken before trace memory sweep");

endmodule

bind spiking_neuron_update snu_checks u_checks (.*);
